// ===== src/stmo_pkg.sv =====
// Shared types and codes for the sparse-table range max/OR engine.
`default_nettype none

package stmo_pkg;

	localparam int VAL_FIELD_BITS = 20;
	localparam int IDXF_BITS      = 10;
	localparam int LEN_BITS       = 11;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2
	} stmo_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUILD,
		ST_QRD,
		ST_QOUT
	} stmo_state_t;

	typedef struct packed {
		logic [1:0]                operation;
		logic [VAL_FIELD_BITS-1:0] element_value;
		logic [IDXF_BITS-1:0]      left_index;
		logic [IDXF_BITS-1:0]      right_index;
	} stmo_cmd_t;

	typedef struct packed {
		logic [VAL_FIELD_BITS-1:0] range_max;
		logic [VAL_FIELD_BITS-1:0] range_or;
		logic                      query_error;
	} stmo_result_t;

endpackage

`default_nettype wire

// ===== src/sparse_table_range_max_or.sv =====
// Top level of the sparse-table range maximum / OR query engine.
//
// Command channel: a command beat is taken at a rising edge with start high
// and busy low. The operation field picks load, build or query.
//   Load  - writes element_value at position left_index of level 0 and
//           leaves busy low. It invalidates the built table.
//   Build - walks levels 1..LEVELS-1, one table entry per cycle through the
//           shared combine unit, with a spare level-end step after each level;
//           busy stays high throughout. The pace is set by the table memory,
//           which gives two reads and one write per cycle.
//   Query - busy through ST_QRD (decode and table read), then ST_QOUT
//           (combine); the result beat appears on result with done high
//           in the same cycle busy falls, so a new query can be taken
//           while that result beat shows.
// Result channel: done marks each result beat for exactly one cycle; the
// receiver cannot hold it off. Loads and builds give no result beat.
// Configuration channel: cfg_valid/cfg_ready/cfg_data writes array_length;
// ready only while idle. Any write invalidates the built table.
// Reset: clears the control state, array_length to 1 and the built flag.
// The table memory itself is not cleared; no clearing pass is run.
`default_nettype none

module sparse_table_range_max_or #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int LEVELS       = 11,
	parameter int VALUE_BITS   = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  stmo_pkg::stmo_cmd_t            cmd,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [stmo_pkg::LEN_BITS-1:0]  cfg_data,
	output logic                           done,
	output stmo_pkg::stmo_result_t         result
);
	import stmo_pkg::*;

	localparam int IDX_W  = $clog2(MAX_ELEMENTS);
	localparam int CNT_W  = $clog2(MAX_ELEMENTS+1);
	localparam int LVL_W  = $clog2(LEVELS);
	localparam int AW     = LVL_W + IDX_W;
	localparam int DEPTH  = LEVELS * (2**IDX_W);
	localparam int SUM_W  = ((CNT_W > LEVELS-1) ? CNT_W : LEVELS-1) + 1;
	localparam int WORD_W = 2 * VALUE_BITS;

	localparam logic [LVL_W-1:0]          LVL_LAST = LVL_W'(LEVELS - 1);
	localparam logic [CNT_W+LEN_BITS-1:0] MAX_LX   = (CNT_W+LEN_BITS)'(MAX_ELEMENTS);
	localparam logic [CNT_W+IDXF_BITS-1:0] MAX_IX  = (CNT_W+IDXF_BITS)'(MAX_ELEMENTS);

	// control state
	stmo_state_t          state_q, state_d;
	logic [LEN_BITS-1:0]  len_cfg_q;
	logic                 built_q;
	logic [LVL_W-1:0]     lvl_q;
	logic [SUM_W-1:0]     half_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 bld_v_s1;
	logic                 done_q;

	// payload registers
	logic                 bld_pair_s1;
	logic [AW-1:0]        bld_addr_s1;
	logic [IDXF_BITS-1:0] left_q, right_q;
	logic                 qerr_q;
	stmo_result_t         result_q;

	// table memory: each word holds {max, or}
	logic [WORD_W-1:0]    mem [DEPTH];
	logic [WORD_W-1:0]    rd_a_q, rd_b_q;

	logic                 accept, bld_issue, level_end, q_read, q_out, load_ok;
	logic [CNT_W-1:0]     used_len;
	logic [CNT_W+LEN_BITS-1:0]  len_x;
	logic [CNT_W+IDXF_BITS-1:0] left_x;
	logic [VALUE_BITS+VAL_FIELD_BITS-1:0] val_x;
	logic [VALUE_BITS-1:0] load_val;

	logic [SUM_W+CNT_W-1:0] idx_xx, len_xx;
	logic [SUM_W-1:0]     idx_s, len_s, pair_sum;
	logic                 bld_pair;
	logic [LVL_W-1:0]     lvl_rd;
	logic [AW-1:0]        bld_addr_a, bld_addr_b;

	logic                 q_err;
	logic [LVL_W-1:0]     q_lvl;
	logic [IDX_W-1:0]     q_first, q_second;

	logic [AW-1:0]        rd_addr_a, rd_addr_b, wr_addr;
	logic [WORD_W-1:0]    wr_data, merged;
	logic                 wr_en, merge_pair;
	logic [VALUE_BITS+VAL_FIELD_BITS-1:0] max_x, or_x;

	// length in use, saturated to the table size (MAX_ELEMENTS)
	assign len_x    = {{CNT_W{1'b0}}, len_cfg_q};
	assign used_len = (len_x > MAX_LX) ? MAX_LX[CNT_W-1:0] : len_x[CNT_W-1:0];

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd.operation == OP_BUILD) state_d = ST_BUILD;
					else if (cmd.operation == OP_QUERY) state_d = ST_QRD;
				end
			end
			ST_BUILD: begin
				if (!(idx_q < used_len) && (lvl_q == LVL_LAST)) state_d = ST_IDLE;
			end
			ST_QRD:  state_d = ST_QOUT;
			ST_QOUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		busy      = 1'b1;
		bld_issue = 1'b0;
		level_end = 1'b0;
		q_read    = 1'b0;
		q_out     = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_BUILD: begin
				bld_issue = (idx_q < used_len);
				level_end = !(idx_q < used_len);
			end
			ST_QRD:   q_read = 1'b1;
			ST_QOUT:  q_out  = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	// load: position beyond the table writes nothing
	assign left_x   = {{CNT_W{1'b0}}, cmd.left_index};
	assign load_ok  = accept && (cmd.operation == OP_LOAD) && (left_x < MAX_IX);
	assign val_x    = {{VALUE_BITS{1'b0}}, cmd.element_value};
	assign load_val = val_x[VALUE_BITS-1:0];

	// build addressing: entry i of the level below and its partner i + half
	assign idx_xx     = {{SUM_W{1'b0}}, idx_q};
	assign len_xx     = {{SUM_W{1'b0}}, used_len};
	assign idx_s      = idx_xx[SUM_W-1:0];
	assign len_s      = len_xx[SUM_W-1:0];
	assign pair_sum   = idx_s + half_q;
	assign bld_pair   = (pair_sum < len_s);
	assign lvl_rd     = lvl_q - LVL_W'(1);
	assign bld_addr_a = {lvl_rd, idx_q[IDX_W-1:0]};
	assign bld_addr_b = {lvl_rd, bld_pair ? pair_sum[IDX_W-1:0] : idx_q[IDX_W-1:0]};

	stmo_qdec #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.LEVELS       (LEVELS)
	) u_qdec (
		.left   (left_q),
		.right  (right_q),
		.len    (used_len),
		.built  (built_q),
		.err    (q_err),
		.lvl    (q_lvl),
		.first  (q_first),
		.second (q_second)
	);

	// one combine unit for build entries and query results
	assign merge_pair = q_out ? 1'b1 : bld_pair_s1;

	stmo_merge #(
		.VALUE_BITS (VALUE_BITS)
	) u_merge (
		.word_a (rd_a_q),
		.word_b (rd_b_q),
		.pair   (merge_pair),
		.word_y (merged)
	);

	assign rd_addr_a = q_read ? {q_lvl, q_first}  : bld_addr_a;
	assign rd_addr_b = q_read ? {q_lvl, q_second} : bld_addr_b;

	// build writeback has the port while busy; loads only arrive when idle
	assign wr_en   = bld_v_s1 || load_ok;
	assign wr_addr = bld_v_s1 ? bld_addr_s1 : {LVL_W'(0), left_x[IDX_W-1:0]};
	assign wr_data = bld_v_s1 ? merged : {load_val, load_val};

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_cfg_q <= LEN_BITS'(1);
			built_q   <= 1'b0;
			lvl_q     <= LVL_W'(1);
			half_q    <= SUM_W'(1);
			idx_q     <= '0;
			bld_v_s1  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			bld_v_s1 <= bld_issue;
			done_q   <= q_out;
			if (cfg_valid && cfg_ready) begin
				len_cfg_q <= cfg_data;
				built_q   <= 1'b0;
			end
			if (accept && (cmd.operation == OP_LOAD)) built_q <= 1'b0;
			if (accept && (cmd.operation == OP_BUILD)) begin
				lvl_q  <= LVL_W'(1);
				half_q <= SUM_W'(1);
				idx_q  <= '0;
			end
			if (bld_issue) idx_q <= idx_q + CNT_W'(1);
			// advance to the next level, or finish on the top one
			if (level_end) begin
				if (lvl_q == LVL_LAST) begin
					built_q <= 1'b1;
				end else begin
					lvl_q  <= lvl_q + LVL_W'(1);
					half_q <= half_q << 1;
					idx_q  <= '0;
				end
			end
		end
	end

	// query result, zeroed on error
	assign max_x = {{VAL_FIELD_BITS{1'b0}}, merged[WORD_W-1:VALUE_BITS]};
	assign or_x  = {{VAL_FIELD_BITS{1'b0}}, merged[VALUE_BITS-1:0]};

	always_ff @(posedge clk) begin
		bld_pair_s1 <= bld_pair;
		bld_addr_s1 <= {lvl_q, idx_q[IDX_W-1:0]};
		if (accept) begin
			left_q  <= cmd.left_index;
			right_q <= cmd.right_index;
		end
		if (q_read) qerr_q <= q_err;
		if (q_out) begin
			result_q.range_max   <= qerr_q ? '0 : max_x[VAL_FIELD_BITS-1:0];
			result_q.range_or    <= qerr_q ? '0 : or_x[VAL_FIELD_BITS-1:0];
			result_q.query_error <= qerr_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a result beat only ever follows the combine cycle of a query
	a_done_after_qout: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_QOUT))
		else $error("result beat without a query combine cycle");

	// build writeback never lands on the element level
	a_build_not_level0: assert property (@(posedge clk) disable iff (!arst_n)
		bld_v_s1 |-> (bld_addr_s1[AW-1:IDX_W] != '0))
		else $error("build write aimed at level 0");

	// an error beat carries an all-zero payload
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.query_error) |->
			((result_q.range_max == '0) && (result_q.range_or == '0)))
		else $error("error result with non-zero payload");

endmodule

`default_nettype wire

// ===== src/stmo_merge.sv =====
// Shared combine unit: pairwise maximum and bitwise OR of two table words.
`default_nettype none

module stmo_merge #(
	parameter int VALUE_BITS = 20
) (
	input  logic [2*VALUE_BITS-1:0] word_a,
	input  logic [2*VALUE_BITS-1:0] word_b,
	input  logic                    pair,
	output logic [2*VALUE_BITS-1:0] word_y
);
	import stmo_pkg::*;

	logic [VALUE_BITS-1:0] a_max, a_or, b_max, b_or, y_max, y_or;

	assign a_max = word_a[2*VALUE_BITS-1:VALUE_BITS];
	assign a_or  = word_a[VALUE_BITS-1:0];
	assign b_max = word_b[2*VALUE_BITS-1:VALUE_BITS];
	assign b_or  = word_b[VALUE_BITS-1:0];

	// drop the second word when there is no partner block
	assign y_max  = (pair && (b_max > a_max)) ? b_max : a_max;
	assign y_or   = pair ? (a_or | b_or) : a_or;
	assign word_y = {y_max, y_or};

endmodule

`default_nettype wire

// ===== src/stmo_qdec.sv =====
// Query decoder: range check, block level and the two block start positions.
`default_nettype none

module stmo_qdec #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int LEVELS       = 11
) (
	input  logic [stmo_pkg::IDXF_BITS-1:0]        left,
	input  logic [stmo_pkg::IDXF_BITS-1:0]        right,
	input  logic [$clog2(MAX_ELEMENTS+1)-1:0]     len,
	input  logic                                  built,
	output logic                                  err,
	output logic [$clog2(LEVELS)-1:0]             lvl,
	output logic [$clog2(MAX_ELEMENTS)-1:0]       first,
	output logic [$clog2(MAX_ELEMENTS)-1:0]       second
);
	import stmo_pkg::*;

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS+1);
	localparam int LVL_W = $clog2(LEVELS);
	localparam int KW    = $clog2(LEN_BITS);
	localparam int KXW   = KW + LVL_W;
	localparam logic [KXW-1:0] LVL_TOP = KXW'(LEVELS - 1);

	logic [LEN_BITS-1:0]          span, pow, sec_w;
	logic [KW-1:0]                k_raw;
	logic [KXW-1:0]               k_x, k_c;
	logic [CNT_W+IDXF_BITS-1:0]   right_x, len_x;
	logic [IDX_W+LEN_BITS-1:0]    sec_x, first_x;

	assign span = {1'b0, right} - {1'b0, left} + LEN_BITS'(1);

	// floor log2 of the range length
	always_comb begin
		k_raw = '0;
		for (int b = 0; b < LEN_BITS; b++) begin
			if (span[b]) k_raw = KW'(b);
		end
	end

	assign k_x   = {{LVL_W{1'b0}}, k_raw};
	assign k_c   = (k_x > LVL_TOP) ? LVL_TOP : k_x;
	assign lvl   = k_c[LVL_W-1:0];
	assign pow   = LEN_BITS'(1) << k_c;
	assign sec_w = {1'b0, right} + LEN_BITS'(1) - pow;

	assign sec_x   = {{IDX_W{1'b0}}, sec_w};
	assign first_x = {{IDX_W{1'b0}}, 1'b0, left};
	assign second  = sec_x[IDX_W-1:0];
	assign first   = first_x[IDX_W-1:0];

	assign right_x = {{CNT_W{1'b0}}, right};
	assign len_x   = {{IDXF_BITS{1'b0}}, len};
	assign err     = !built || (left > right) || (right_x >= len_x);

endmodule

`default_nettype wire

// ===== dv/sparse_table_range_max_or_tb.sv =====
// Self-checking testbench for the sparse-table range maximum / OR query engine.
`default_nettype none

module sparse_table_range_max_or_tb;
	import stmo_pkg::*;

	// Operation code that the block must ignore without a result beat.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int LEVEL_COUNT = 11;
	// Quiet cycles allowed before the run is declared hung: a full-length build
	// is the longest legal quiet stretch, and the pause before a length write
	// matches it, so this limit is several times that stretch.
	localparam int QUIET_LIMIT = 60000;
	localparam int ITEM_TARGET = 1300;

	// Tracks the element array, the length register and the built flag, and
	// holds the query answers that are still owed by the block.
	class range_query_tracker;
		localparam int DEPTH = 1024;

		bit [VAL_FIELD_BITS-1:0] elem [DEPTH];
		bit                      ever_loaded [DEPTH];
		bit [LEN_BITS-1:0]       length_reg = 11'd1;
		bit                      table_ready;
		stmo_result_t            answers_due [$];
		int                      mismatches;

		function int unsigned used_length();
			return (length_reg > DEPTH) ? DEPTH : length_reg;
		endfunction

		function void set_length(bit [LEN_BITS-1:0] v);
			length_reg  = v;
			table_ready = 1'b0;
		endfunction

		function void take_command(stmo_cmd_t c);
			stmo_result_t r;
			case (c.operation)
				OP_LOAD: begin
					elem[c.left_index]        = c.element_value;
					ever_loaded[c.left_index] = 1'b1;
					table_ready               = 1'b0;
				end
				OP_BUILD: begin
					table_ready = 1'b1;
				end
				OP_QUERY: begin
					r             = '0;
					r.query_error = 1'b1;
					if (table_ready && c.left_index <= c.right_index &&
					    c.right_index < used_length()) begin
						r.query_error = 1'b0;
						for (int i = c.left_index; i <= c.right_index; i++) begin
							if (elem[i] > r.range_max)
								r.range_max = elem[i];
							r.range_or |= elem[i];
						end
					end
					answers_due.push_back(r);
				end
				default: begin
				end
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_answer(stmo_result_t got);
			stmo_result_t want;
			if (answers_due.size() == 0) begin
				report("result beat with no query outstanding");
			end else begin
				want = answers_due.pop_front();
				if (got.range_max !== want.range_max)
					report($sformatf("range_max %h, want %h", got.range_max, want.range_max));
				if (got.range_or !== want.range_or)
					report($sformatf("range_or %h, want %h", got.range_or, want.range_or));
				if (got.query_error !== want.query_error)
					report($sformatf("query_error %b, want %b",
						got.query_error, want.query_error));
			end
		endtask
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic                busy;
	stmo_cmd_t           cmd       = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [LEN_BITS-1:0] cfg_data  = '0;
	logic                done;
	stmo_result_t        result;

	range_query_tracker sb = new();
	int unsigned        burst_left;
	int unsigned        items_sent;
	int                 quiet_cycles;

	sparse_table_range_max_or dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check each result beat in the cycle it is shown; the receiver never stalls.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_answer(result);
	end

	// Hang detection: count cycles with no beat on any channel.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Drive one command beat. The sender works in bursts; a gap drops start for
	// a few cycles first. Start is left high after the beat so that a following
	// beat in the same burst can go out at once; callers that pause lower it.
	task automatic issue_cmd(input logic [1:0] op, input logic [VAL_FIELD_BITS-1:0] val,
	                         input logic [IDXF_BITS-1:0] lft, input logic [IDXF_BITS-1:0] rgt);
		stmo_cmd_t   c;
		int unsigned gap;
		c.operation     = op;
		c.element_value = val;
		c.left_index    = lft;
		c.right_index   = rgt;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.take_command(c);
		items_sent++;
	endtask

	// Write the length register once the block has gone quiet. Loads and
	// builds give no result beat, so hold off for as long as a build over the
	// current length could still be running.
	task automatic write_length(input logic [LEN_BITS-1:0] v);
		start <= 1'b0;
		while (sb.answers_due.size() != 0)
			@(posedge clk);
		repeat ((LEVEL_COUNT - 1) * (sb.used_length() + 1) + 8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_length(v);
		cfg_valid <= 1'b0;
	endtask

	// One phase: set a length, make sure every position it covers holds a
	// loaded element, build, then a random mix of queries, reloads, rebuilds and unused codes.
	task automatic run_phase(input logic [LEN_BITS-1:0] len_val, input int unsigned n_ops);
		int unsigned          used;
		int unsigned          pick;
		logic [IDXF_BITS-1:0] lo;
		logic [IDXF_BITS-1:0] hi;
		write_length(len_val);
		used = sb.used_length();
		for (int i = 0; i < used; i++) begin
			if (!sb.ever_loaded[i])
				issue_cmd(OP_LOAD, 20'($urandom), 10'(i), 10'($urandom));
		end
		repeat ($urandom_range(0, 3))
			issue_cmd(OP_LOAD, 20'($urandom), 10'($urandom), 10'($urandom));
		// Now and then ask before building: the table is stale.
		if ($urandom_range(0, 4) == 0)
			issue_cmd(OP_QUERY, 20'($urandom), 10'($urandom_range(0, 1023)),
				10'($urandom_range(0, 1023)));
		issue_cmd(OP_BUILD, 20'($urandom), 10'($urandom), 10'($urandom));
		repeat (n_ops) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				issue_cmd(OP_LOAD, 20'($urandom), 10'($urandom), 10'($urandom));
			end else if (pick == 1) begin
				issue_cmd(OP_BUILD, 20'($urandom), 10'($urandom), 10'($urandom));
			end else if (pick == 2) begin
				issue_cmd(OP_UNUSED, 20'($urandom), 10'($urandom), 10'($urandom));
			end else if (pick <= 4 || used == 0) begin
				issue_cmd(OP_QUERY, 20'($urandom), 10'($urandom), 10'($urandom));
			end else if (pick == 5) begin
				hi = 10'($urandom_range(0, 1022));
				lo = 10'($urandom_range(hi + 1, 1023));
				issue_cmd(OP_QUERY, 20'($urandom), lo, hi);
			end else begin
				if (pick == 6) begin
					lo = '0;
					hi = 10'(used - 1);
				end else begin
					lo = 10'($urandom_range(0, used - 1));
					hi = 10'($urandom_range(lo, used - 1));
				end
				issue_cmd(OP_QUERY, 20'($urandom), lo, hi);
			end
		end
	endtask

	function automatic logic [LEN_BITS-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 19);
		case (r)
			0:       return 11'd0;
			1:       return 11'd1;
			2:       return 11'd1024;
			3:       return 11'($urandom_range(1025, 2047));
			4, 5:    return 11'($urandom_range(100, 400));
			default: return 11'($urandom_range(2, 40));
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset length of one.
		issue_cmd(OP_QUERY, 20'h00000, 10'd0, 10'd0);       // nothing built yet
		issue_cmd(OP_UNUSED, 20'hFFFFF, 10'h3FF, 10'h3FF);  // ignored, no beat
		issue_cmd(OP_LOAD, 20'hFFFFF, 10'd0, 10'h3FF);
		issue_cmd(OP_QUERY, 20'h00000, 10'd0, 10'd0);       // load dropped the table
		issue_cmd(OP_BUILD, 20'h00000, 10'd0, 10'd0);
		issue_cmd(OP_QUERY, 20'h00000, 10'd0, 10'd0);
		issue_cmd(OP_QUERY, 20'h00000, 10'd1, 10'd0);       // left above right
		issue_cmd(OP_QUERY, 20'h00000, 10'd0, 10'd1);       // right past the end
		issue_cmd(OP_LOAD, 20'h00000, 10'h3FF, 10'd0);      // load outside the length
		issue_cmd(OP_QUERY, 20'h00000, 10'd0, 10'd0);       // still invalidated
		issue_cmd(OP_BUILD, 20'h00000, 10'd0, 10'd0);
		issue_cmd(OP_QUERY, 20'h00000, 10'd0, 10'd0);

		write_length(11'd2);
		issue_cmd(OP_QUERY, 20'h00000, 10'd0, 10'd0);       // length write dropped it
		issue_cmd(OP_LOAD, 20'h5A5A5, 10'd1, 10'd0);
		issue_cmd(OP_BUILD, 20'h00000, 10'd0, 10'd0);
		issue_cmd(OP_QUERY, 20'h00000, 10'd0, 10'd1);
		issue_cmd(OP_QUERY, 20'h00000, 10'd1, 10'd1);

		write_length(11'd0);
		issue_cmd(OP_BUILD, 20'h00000, 10'd0, 10'd0);       // nothing to combine
		issue_cmd(OP_QUERY, 20'h00000, 10'd0, 10'd0);       // every query fails

		// Random part: first the widest length, saturated, so the whole array
		// is loaded once; then mostly short lengths.
		run_phase(11'd2047, 40);
		while (items_sent < ITEM_TARGET)
			run_phase(pick_length(), $urandom_range(10, 40));

		// Drain: wait for every owed answer, then a short tail for strays.
		start <= 1'b0;
		while (sb.answers_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (sb.mismatches == 0 && sb.answers_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
